// ===== design/gdft_pkg.sv =====
// shared constants, codes and sequencer states of the graph traversal unit
`timescale 1ns / 1ps

package gdft_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_EDGES_DEF    = 64;
    localparam int RESULT_LIMIT     = 32;
    localparam int RESULT_CNT_W     = $clog2(RESULT_LIMIT + 1);

    localparam int OP_W      = 2;
    localparam int VERTEX_W  = 5;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_TRAVERSE = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VISITED = 2'd0,
        ST_FULL    = 2'd1,
        ST_NONE    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_SEND_FULL,
        S_SCAN,
        S_VISIT,
        S_PUSH,
        S_LOOP,
        S_EDGE,
        S_POP,
        S_POP_LD,
        S_FINISH
    } state_t;

endpackage

// ===== design/graph_depth_first_traversal_unit.sv =====
// top level of the graph depth-first traversal unit
// A directed graph of up to MAX_VERTICES vertices is held as linked edge lists in an
// edge memory of MAX_EDGES slots, the newest edge of a vertex at the head of its list.
// Requests: add edge (op 0, or a full status result when the edge memory is full),
// traverse (op 1) and clear (op 2). A traverse runs a sequencer over the list-head,
// edge and stack memories, each with a registered read port: it scans the start
// vertices in order, visits each unvisited one, follows its edges depth-first through
// a stack of edge cursors and pops the stack at the end of a list, then finishes with
// a last result; result back-pressure can stall it. The visited map survives between
// traversals until a clear. The input side is not ready while a request is
// in progress. The vertex count register may be written at any time the unit is idle.
`timescale 1ns / 1ps

module graph_depth_first_traversal_unit #(
    parameter int MAX_VERTICES = gdft_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = gdft_pkg::MAX_EDGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // op [1:0], from_vertex [6:2], to_vertex [11:7]
    input  logic [gdft_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // vertex_index [4:0], status [6:5]
    output logic [gdft_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [gdft_pkg::COUNT_W-1:0]      cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam logic [EW-1:0] NULL_EDGE = EW'(MAX_EDGES);

    gdft_pkg::state_t state_reg, state_next;

    logic [gdft_pkg::COUNT_W-1:0]      vcount_reg;
    logic [MAX_VERTICES-1:0]           head_valid_reg, head_valid_next;
    logic [MAX_VERTICES-1:0]           visited_reg, visited_next;
    logic [EW-1:0]                     edges_used_reg, edges_used_next;
    logic [VW:0]                       depth_reg, depth_next;
    logic [VW:0]                       scan_reg, scan_next;
    logic [gdft_pkg::RESULT_CNT_W-1:0] n_reg, n_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [VW-1:0]                     pend_v_reg, pend_v_next;
    logic [VW-1:0]                     v_reg, v_next;
    logic [VW-1:0]                     to_reg, to_next;
    logic [EW-1:0]                     top_cur_reg, top_cur_next;

    logic                              out_valid_reg, out_valid_next;
    logic [gdft_pkg::VERTEX_W-1:0]     out_vertex_reg, out_vertex_next;
    gdft_pkg::status_t                 out_status_reg, out_status_next;
    logic                              out_last_reg, out_last_next;

    // memories
    logic [EIW-1:0]                    head_mem [MAX_VERTICES];
    logic [VW+EW-1:0]                  edge_mem [MAX_EDGES];
    logic [EW-1:0]                     stack_mem [MAX_VERTICES];
    logic [EIW-1:0]                    head_rd_reg;
    logic [VW+EW-1:0]                  edge_rd_reg;
    logic [EW-1:0]                     stack_rd_reg;

    logic                              head_we, edge_we, stack_we;
    logic [VW+EW-1:0]                  edge_wdata;
    logic [VW-1:0]                     stack_waddr;
    logic [EW-1:0]                     stack_wdata;
    logic [VW:0]                       depth_dec;

    logic                              in_fire, out_free;
    gdft_pkg::op_t                     in_op;
    logic [gdft_pkg::VERTEX_W-1:0]     in_from, in_to;
    logic                              add_range_ok, add_full;
    logic                              scan_stop, limit_hit;
    logic [EW-1:0]                     head_cur;
    logic [VW-1:0]                     edge_target;
    logic [EW-1:0]                     edge_link;
    logic                              edge_new;

    assign s_axis_tready = (state_reg == gdft_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign in_op   = gdft_pkg::op_t'(s_axis_tdata[1:0]);
    assign in_from = s_axis_tdata[6:2];
    assign in_to   = s_axis_tdata[11:7];

    assign add_range_ok = (32'(in_from) < MAX_VERTICES) && (32'(in_to) < MAX_VERTICES);
    assign add_full     = (32'(edges_used_reg) >= MAX_EDGES);

    assign limit_hit = (32'(n_reg) >= gdft_pkg::RESULT_LIMIT);
    assign scan_stop = (32'(scan_reg) >= 32'(vcount_reg)) ||
                       (32'(scan_reg) >= MAX_VERTICES) || limit_hit;

    assign head_cur    = head_valid_reg[v_reg] ? EW'(head_rd_reg) : NULL_EDGE;
    assign edge_target = edge_rd_reg[VW+EW-1:EW];
    assign edge_link   = edge_rd_reg[EW-1:0];
    assign edge_new    = (32'(edge_target) < MAX_VERTICES) && !visited_reg[edge_target];
    assign depth_dec   = depth_reg - 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_status_reg, out_vertex_reg};
    assign m_axis_tlast  = out_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gdft_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (in_op)
                        gdft_pkg::OP_ADD: begin
                            if (!add_range_ok) state_next = gdft_pkg::S_IDLE;
                            else if (add_full) state_next = gdft_pkg::S_SEND_FULL;
                            else               state_next = gdft_pkg::S_ADD_RD;
                        end
                        gdft_pkg::OP_TRAVERSE: state_next = gdft_pkg::S_SCAN;
                        default:               state_next = gdft_pkg::S_IDLE;
                    endcase
                end
            end
            gdft_pkg::S_ADD_RD:    state_next = gdft_pkg::S_ADD_WR;
            gdft_pkg::S_ADD_WR:    state_next = gdft_pkg::S_IDLE;
            gdft_pkg::S_SEND_FULL: if (out_free) state_next = gdft_pkg::S_IDLE;
            gdft_pkg::S_SCAN: begin
                if (scan_stop)                       state_next = gdft_pkg::S_FINISH;
                else if (!visited_reg[scan_reg[VW-1:0]]) state_next = gdft_pkg::S_VISIT;
            end
            gdft_pkg::S_VISIT: if (!pend_valid_reg || out_free) state_next = gdft_pkg::S_PUSH;
            gdft_pkg::S_PUSH:  state_next = gdft_pkg::S_LOOP;
            gdft_pkg::S_LOOP: begin
                priority if (depth_reg == '0 || limit_hit) state_next = gdft_pkg::S_SCAN;
                else if (top_cur_reg == NULL_EDGE) begin
                    if (depth_reg > (VW+1)'(1)) state_next = gdft_pkg::S_POP;
                end
                else state_next = gdft_pkg::S_EDGE;
            end
            gdft_pkg::S_EDGE:   state_next = edge_new ? gdft_pkg::S_VISIT : gdft_pkg::S_LOOP;
            gdft_pkg::S_POP:    state_next = gdft_pkg::S_POP_LD;
            gdft_pkg::S_POP_LD: state_next = gdft_pkg::S_LOOP;
            gdft_pkg::S_FINISH: if (out_free) state_next = gdft_pkg::S_IDLE;
            default:            state_next = gdft_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        head_valid_next = head_valid_reg;
        visited_next    = visited_reg;
        edges_used_next = edges_used_reg;
        depth_next      = depth_reg;
        scan_next       = scan_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_v_next     = pend_v_reg;
        v_next          = v_reg;
        to_next         = to_reg;
        top_cur_next    = top_cur_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_vertex_next = out_vertex_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        head_we         = 1'b0;
        edge_we         = 1'b0;
        stack_we        = 1'b0;
        edge_wdata      = {to_reg, head_cur};
        stack_waddr     = depth_reg[VW-1:0];
        stack_wdata     = head_cur;

        unique case (state_reg)
            gdft_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (in_op)
                        gdft_pkg::OP_ADD: begin
                            v_next  = VW'(in_from);
                            to_next = VW'(in_to);
                        end
                        gdft_pkg::OP_TRAVERSE: begin
                            scan_next       = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                        end
                        gdft_pkg::OP_CLEAR: begin
                            head_valid_next = '0;
                            visited_next    = '0;
                            edges_used_next = '0;
                            depth_next      = '0;
                        end
                        default: ;
                    endcase
                end
            end
            gdft_pkg::S_ADD_RD: ;
            gdft_pkg::S_ADD_WR: begin
                head_we                = 1'b1;
                edge_we                = 1'b1;
                head_valid_next[v_reg] = 1'b1;
                edges_used_next        = edges_used_reg + 1'b1;
            end
            gdft_pkg::S_SEND_FULL: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = '0;
                    out_status_next = gdft_pkg::ST_FULL;
                    out_last_next   = 1'b1;
                end
            end
            gdft_pkg::S_SCAN: begin
                depth_next = '0;
                if (!scan_stop) begin
                    v_next    = scan_reg[VW-1:0];
                    scan_next = scan_reg + 1'b1;
                end
            end
            gdft_pkg::S_VISIT: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_vertex_next = gdft_pkg::VERTEX_W'(pend_v_reg);
                        out_status_next = gdft_pkg::ST_VISITED;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next     = 1'b1;
                    pend_v_next         = v_reg;
                    visited_next[v_reg] = 1'b1;
                    n_next              = n_reg + 1'b1;
                end
            end
            gdft_pkg::S_PUSH: begin
                stack_we     = 1'b1;
                top_cur_next = head_cur;
                depth_next   = depth_reg + 1'b1;
            end
            gdft_pkg::S_LOOP: begin
                priority if (depth_reg == '0 || limit_hit) depth_next = '0;
                else if (top_cur_reg == NULL_EDGE) depth_next = depth_dec;
                else ;
            end
            gdft_pkg::S_EDGE: begin
                stack_we     = 1'b1;
                stack_waddr  = depth_dec[VW-1:0];
                stack_wdata  = edge_link;
                top_cur_next = edge_link;
                if (edge_new) v_next = edge_target;
            end
            gdft_pkg::S_POP: ;
            gdft_pkg::S_POP_LD: top_cur_next = stack_rd_reg;
            gdft_pkg::S_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        out_vertex_next = gdft_pkg::VERTEX_W'(pend_v_reg);
                        out_status_next = gdft_pkg::ST_VISITED;
                    end else begin
                        out_vertex_next = '0;
                        out_status_next = gdft_pkg::ST_NONE;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gdft_pkg::S_IDLE;
            vcount_reg     <= '0;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            edges_used_reg <= '0;
            depth_reg      <= '0;
            scan_reg       <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready) vcount_reg <= cfg_data;
            head_valid_reg <= head_valid_next;
            visited_reg    <= visited_next;
            edges_used_reg <= edges_used_next;
            depth_reg      <= depth_next;
            scan_reg       <= scan_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_v_reg     <= pend_v_next;
        v_reg          <= v_next;
        to_reg         <= to_next;
        top_cur_reg    <= top_cur_next;
        out_vertex_reg <= out_vertex_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // list head memory
    always_ff @(posedge aclk) begin
        if (head_we) head_mem[v_reg] <= edges_used_reg[EIW-1:0];
        head_rd_reg <= head_mem[v_reg];
    end

    // edge memory: target and link to next edge of the same source
    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edges_used_reg[EIW-1:0]] <= edge_wdata;
        edge_rd_reg <= edge_mem[top_cur_reg[EIW-1:0]];
    end

    // walk stack of edge cursors
    always_ff @(posedge aclk) begin
        if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
        stack_rd_reg <= stack_mem[depth_dec[VW-1:0]];
    end

endmodule
